/* design/ael_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ael_pkg
// Shared codes and constants for the arithmetic expression lexer.
// ----------------------------------------------------------------------------
package ael_pkg;

  localparam int unsigned MAX_TEXT_DEFAULT = 4096;
  localparam int unsigned FIFO_DEPTH       = 4;

  localparam int unsigned KIND_W  = 4;
  localparam int unsigned VALUE_W = 31;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // token kinds
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SPACE  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_STAR   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd7;
  localparam logic [KIND_W-1:0] KIND_BAD    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_EOF    = 4'd9;

  // open run codes
  localparam logic [1:0] RUN_NONE   = 2'd0;
  localparam logic [1:0] RUN_NUMBER = 2'd1;
  localparam logic [1:0] RUN_SPACE  = 2'd2;

  // command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

endpackage

/* design/arith_expression_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arith_expression_lexer
// Streaming tokenizer: bytes in, number/space/operator/bad/eof tokens out.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall   | command, ch
// output  | out       | out_valid/out_stall | token_kind, start_pos, token_len,
//         |           |                     | number_value, overflow, token_char, last
//
// one request is taken per cycle while in_stall is low; its tokens are formed in
// the same cycle and written into a four-entry result queue, which drains one
// token per cycle while out_stall is low. a request that closes a run and also
// emits a token writes two entries, so in_stall rises while fewer than two queue
// entries are free. tokens reach the output from the registered queue, in order.
// synchronous reset empties the queue and closes any open run at position 0.
// ----------------------------------------------------------------------------
module arith_expression_lexer
  import ael_pkg::*;
#(
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [7:0]                   ch,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [KIND_W-1:0]            token_kind,
  output logic [$clog2(MAX_TEXT)-1:0]  start_pos,
  output logic [$clog2(MAX_TEXT+1)-1:0] token_len,
  output logic [VALUE_W-1:0]           number_value,
  output logic                         overflow,
  output logic [7:0]                   token_char,
  output logic                         last
);

  localparam int unsigned PW   = $clog2(MAX_TEXT);
  localparam int unsigned LW   = $clog2(MAX_TEXT + 1);
  localparam int unsigned AW   = $clog2(FIFO_DEPTH);
  localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_TEXT - 1);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_TEXT);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PW-1:0]      start;
    logic [LW-1:0]      len;
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic [7:0]         chr;
    logic               last;
  } tok_t;

  // run state
  logic [1:0]         run_kind;
  logic [PW-1:0]      run_start;
  logic [LW-1:0]      run_length;
  logic [VALUE_W-1:0] run_value;
  logic               run_overflow;
  logic [PW-1:0]      char_position;

  // result queue
  tok_t               fifo_mem [FIFO_DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      count;

  logic               in_accept;
  logic               out_accept;
  logic [1:0]         cls;
  logic [3:0]         digit;
  logic [VALUE_W+3:0] value_prod;
  logic [VALUE_W-1:0] value_next;
  logic               overflow_next;
  logic [KIND_W-1:0]  single_kind;
  logic               close_run;
  logic               has_a;
  logic               has_b;
  tok_t               tok_a;
  tok_t               tok_b;
  tok_t               slot0;
  logic [1:0]         n_push;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (count > CW'(FIFO_DEPTH - 2));
  assign out_valid  = (count != '0);

  // character class
  always_comb begin
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      cls = RUN_NUMBER;
    end else if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE) begin
      cls = RUN_SPACE;
    end else begin
      cls = RUN_NONE;
    end
  end

  always_comb begin
    unique case (ch)
      CH_PLUS:   single_kind = KIND_PLUS;
      CH_MINUS:  single_kind = KIND_MINUS;
      CH_STAR:   single_kind = KIND_STAR;
      CH_SLASH:  single_kind = KIND_SLASH;
      CH_LPAREN: single_kind = KIND_LPAREN;
      CH_RPAREN: single_kind = KIND_RPAREN;
      default:   single_kind = KIND_BAD;
    endcase
  end

  // value * 10 + digit with saturation
  assign digit      = ch[3:0];
  assign value_prod = ({4'b0, run_value} << 3) + ({4'b0, run_value} << 1)
                      + (VALUE_W+4)'(digit);
  always_comb begin
    if (value_prod > (VALUE_W+4)'(VALUE_MAX)) begin
      value_next    = VALUE_MAX;
      overflow_next = 1'b1;
    end else begin
      value_next    = value_prod[VALUE_W-1:0];
      overflow_next = run_overflow;
    end
  end

  // tokens for the current request
  always_comb begin
    close_run = (run_kind != RUN_NONE) && ((command == CMD_END) || (cls != run_kind));
    has_a     = close_run;
    has_b     = (command == CMD_END) || (cls == RUN_NONE);

    tok_a.kind  = (run_kind == RUN_NUMBER) ? KIND_NUMBER : KIND_SPACE;
    tok_a.start = run_start;
    tok_a.len   = run_length;
    tok_a.value = (run_kind == RUN_NUMBER) ? run_value : '0;
    tok_a.ovf   = (run_kind == RUN_NUMBER) ? run_overflow : 1'b0;
    tok_a.chr   = '0;
    tok_a.last  = !has_b;

    if (command == CMD_END) begin
      tok_b.kind = KIND_EOF;
      tok_b.len  = '0;
      tok_b.chr  = '0;
    end else begin
      tok_b.kind = single_kind;
      tok_b.len  = LW'(1);
      tok_b.chr  = ch;
    end
    tok_b.start = char_position;
    tok_b.value = '0;
    tok_b.ovf   = 1'b0;
    tok_b.last  = 1'b1;

    slot0  = has_a ? tok_a : tok_b;
    n_push = {1'b0, has_a} + {1'b0, has_b};
  end

  // run state update
  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind      <= RUN_NONE;
      run_start     <= '0;
      run_length    <= '0;
      run_value     <= '0;
      run_overflow  <= 1'b0;
      char_position <= '0;
    end else if (in_accept) begin
      if (command == CMD_END) begin
        run_kind      <= RUN_NONE;
        run_start     <= '0;
        run_length    <= '0;
        run_value     <= '0;
        run_overflow  <= 1'b0;
        char_position <= '0;
      end else begin
        if (cls == RUN_NONE) begin
          run_kind     <= RUN_NONE;
          run_length   <= '0;
          run_value    <= '0;
          run_overflow <= 1'b0;
        end else if (cls == run_kind) begin
          if (run_length < LEN_LIMIT) begin
            run_length <= run_length + LW'(1);
          end
          if (cls == RUN_NUMBER) begin
            run_value    <= value_next;
            run_overflow <= overflow_next;
          end
        end else begin
          // a new run opens here
          run_kind     <= cls;
          run_start    <= char_position;
          run_length   <= LW'(1);
          run_value    <= (cls == RUN_NUMBER) ? VALUE_W'(digit) : '0;
          run_overflow <= 1'b0;
        end
        if (char_position < POS_LIMIT) begin
          char_position <= char_position + PW'(1);
        end
      end
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fifo_mem[wr_ptr] <= slot0;
      if (has_a && has_b) begin
        fifo_mem[wr_ptr + AW'(1)] <= tok_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr <= wr_ptr + AW'(n_push);
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (in_accept ? CW'(n_push) : CW'(0)) - (out_accept ? CW'(1) : CW'(0));
    end
  end

  assign token_kind   = fifo_mem[rd_ptr].kind;
  assign start_pos    = fifo_mem[rd_ptr].start;
  assign token_len    = fifo_mem[rd_ptr].len;
  assign number_value = fifo_mem[rd_ptr].value;
  assign overflow     = fifo_mem[rd_ptr].ovf;
  assign token_char   = fifo_mem[rd_ptr].chr;
  assign last         = fifo_mem[rd_ptr].last;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // end of text leaves the block at position zero with no open run
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_END) |=> (char_position == '0 && run_kind == RUN_NONE))
    else $error("end of text did not clear run state");

  // no open run means no leftover length or value
  a_idle_run: assert property (@(posedge clk) disable iff (rst)
    (run_kind == RUN_NONE) |-> (run_length == '0 && run_value == '0 && !run_overflow))
    else $error("closed run holds stale data");

  // a queued token always has a legal kind
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind <= KIND_EOF))
    else $error("illegal token kind at output");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the arithmetic expression lexer. A queue of text
// bytes and end-of-text requests is fed through bursty valid/stall traffic,
// every accepted request is tokenized by a local model, and every token that
// leaves the block is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import ael_pkg::*;

  localparam int TEXT_MAX = MAX_TEXT_DEFAULT;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [11:0]        pos;
    logic [12:0]        len;
    logic [VALUE_W-1:0] value;
    logic               ovf;
    logic [7:0]         chr;
    logic               last;
  } token_t;

  typedef struct {
    logic       cmd;
    logic [7:0] c;
    logic       pause;
  } text_req_t;

  logic               clk;
  logic               rst;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_CHAR;
  logic [7:0]         ch = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  token_kind;
  logic [11:0]        start_pos;
  logic [12:0]        token_len;
  logic [VALUE_W-1:0] number_value;
  logic               overflow;
  logic [7:0]         token_char;
  logic               last;

  text_req_t text_q[$];
  token_t    pending_tokens[$];
  logic      pause_next = 1'b0;
  logic      req_taken = 1'b0;
  int        taken_count = 0;
  int        err_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        hold_left = 0;
  int        next_hold_at = 600;
  int        stall_mode = 0;
  int        mode_left = 0;
  int        base_count;

  // lexer state as predicted
  logic [1:0]         open_run = RUN_NONE;
  logic [11:0]        run_begin = '0;
  logic [12:0]        run_count = '0;
  logic [VALUE_W-1:0] run_acc = '0;
  logic               run_sat = 1'b0;
  logic [11:0]        next_pos = '0;

  arith_expression_lexer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .token_len    (token_len),
    .number_value (number_value),
    .overflow     (overflow),
    .token_char   (token_char),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic tokenize_request(input logic cmd, input logic [7:0] c);
    token_t      made[2];
    int          n;
    logic [1:0]  cls;
    logic [11:0] pos;
    logic [63:0] wide;
    n = 0;
    pos = next_pos;
    if (c >= CH_ZERO && c <= CH_NINE) cls = RUN_NUMBER;
    else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) cls = RUN_SPACE;
    else cls = RUN_NONE;
    // end of text or a class change closes the open run
    if (cmd == CMD_END || (open_run != RUN_NONE && cls != open_run)) begin
      if (open_run == RUN_NUMBER) begin
        made[n] = '{KIND_NUMBER, run_begin, run_count, run_acc, run_sat, 8'h00, 1'b0};
        n++;
      end else if (open_run == RUN_SPACE) begin
        made[n] = '{KIND_SPACE, run_begin, run_count, '0, 1'b0, 8'h00, 1'b0};
        n++;
      end
      open_run = RUN_NONE;
      run_count = '0;
      run_acc = '0;
      run_sat = 1'b0;
    end
    if (cmd == CMD_END) begin
      made[n] = '{KIND_EOF, pos, '0, '0, 1'b0, 8'h00, 1'b0};
      n++;
      next_pos = '0;
      run_begin = '0;
    end else begin
      if (cls != RUN_NONE) begin
        if (open_run == RUN_NONE) begin
          open_run = cls;
          run_begin = pos;
        end
        if (run_count < TEXT_MAX) run_count++;
        if (cls == RUN_NUMBER) begin
          wide = 64'(run_acc) * 64'd10 + 64'(c - CH_ZERO);
          if (wide > 64'(VALUE_MAX)) begin
            run_acc = VALUE_MAX;
            run_sat = 1'b1;
          end else begin
            run_acc = wide[VALUE_W-1:0];
          end
        end
      end else begin
        made[n] = '{KIND_BAD, pos, 13'd1, '0, 1'b0, c, 1'b0};
        case (c)
          CH_PLUS:   made[n].kind = KIND_PLUS;
          CH_MINUS:  made[n].kind = KIND_MINUS;
          CH_STAR:   made[n].kind = KIND_STAR;
          CH_SLASH:  made[n].kind = KIND_SLASH;
          CH_LPAREN: made[n].kind = KIND_LPAREN;
          CH_RPAREN: made[n].kind = KIND_RPAREN;
          default:   made[n].kind = KIND_BAD;
        endcase
        n++;
      end
      if (next_pos < TEXT_MAX - 1) next_pos++;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_tokens.insert(pending_tokens.size(), made[i]);
  endtask

  function automatic string token_str(input token_t t);
    return $sformatf("kind=%0d pos=%0d len=%0d value=%0d ovf=%0b chr=%02h last=%0b",
                     t.kind, t.pos, t.len, t.value, t.ovf, t.chr, t.last);
  endfunction

  task automatic queue_item(input logic cmd, input logic [7:0] c);
    text_q.insert(text_q.size(), '{cmd, c, pause_next});
    pause_next = 1'b0;
  endtask

  task automatic queue_end();
    queue_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_number(input logic [63:0] v, input int zeros);
    logic [7:0] digs[$];
    repeat (zeros) queue_item(CMD_CHAR, CH_ZERO);
    do begin
      digs.push_front(CH_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[i]) queue_item(CMD_CHAR, digs[i]);
  endtask

  task automatic queue_space();
    int k;
    k = $urandom_range(0, 5);
    queue_item(CMD_CHAR, (k == 5) ? CH_SPACE : CH_TAB + 8'(k));
  endtask

  task automatic queue_operator();
    case ($urandom_range(0, 5))
      0:       queue_item(CMD_CHAR, CH_PLUS);
      1:       queue_item(CMD_CHAR, CH_MINUS);
      2:       queue_item(CMD_CHAR, CH_STAR);
      3:       queue_item(CMD_CHAR, CH_SLASH);
      4:       queue_item(CMD_CHAR, CH_LPAREN);
      default: queue_item(CMD_CHAR, CH_RPAREN);
    endcase
  endtask

  task automatic queue_random_text();
    int pieces;
    int pick;
    pieces = $urandom_range(1, 20);
    if ($urandom_range(0, 29) == 0) pause_next = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      // broken text: raw bytes
      repeat (pieces) queue_item(CMD_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      repeat (pieces) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          case ($urandom_range(0, 9))
            0:       queue_number(64'(VALUE_MAX), 0);
            1:       queue_number(64'(VALUE_MAX) + 64'd1, 0);
            2:       queue_number({$urandom, $urandom} % 64'd10000000000000, 0);
            3:       queue_number(64'($urandom_range(0, 999)), $urandom_range(1, 3));
            default: queue_number(64'($urandom_range(0, 99999)), 0);
          endcase
        end else if (pick < 60) begin
          repeat ($urandom_range(1, 4)) queue_space();
        end else if (pick < 92) begin
          queue_operator();
        end else begin
          queue_item(CMD_CHAR, 8'($urandom_range(0, 255)));
        end
      end
    end
    queue_end();
  endtask

  // request side: acceptance and prediction
  always @(posedge clk) begin
    req_taken = !rst && in_valid && !in_stall;
    if (req_taken) begin
      tokenize_request(command, ch);
      void'(text_q.pop_front());
      taken_count++;
    end
  end

  // request side: driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // offer held until accepted
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (text_q.size() == 0 || (text_q[0].pause && pending_tokens.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      command <= text_q[0].cmd;
      ch <= text_q[0].c;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(1, 30);
        gap_left <= $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // token side: stall pattern with occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (taken_count >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      next_hold_at <= next_hold_at + 2500;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // token side: monitor
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {token_kind, start_pos, token_len, number_value, overflow, token_char, last};
      if (pending_tokens.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected token: %s", token_str(got));
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("token mismatch\n  expected %s\n  actual   %s",
                     token_str(want), token_str(got));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;

    // directed: empty text, overflow, every operator, all whitespace, odd bytes
    queue_end();
    queue_item(CMD_CHAR, CH_LPAREN);
    queue_number(64'(VALUE_MAX) + 64'd1, 0);
    queue_item(CMD_CHAR, CH_RPAREN);
    for (int i = 0; i < 5; i++) queue_item(CMD_CHAR, CH_TAB + 8'(i));
    queue_item(CMD_CHAR, CH_SPACE);
    queue_item(CMD_CHAR, CH_MINUS);
    queue_item(CMD_CHAR, CH_STAR);
    queue_item(CMD_CHAR, CH_SLASH);
    queue_item(CMD_CHAR, CH_PLUS);
    queue_item(CMD_CHAR, 8'h00);
    queue_item(CMD_CHAR, 8'hFF);
    queue_item(CMD_CHAR, 8'h80);
    queue_item(CMD_CHAR, CH_ZERO);
    queue_end();

    // long text: positions and run length saturate
    pause_next = 1'b1;
    repeat (TEXT_MAX + 4) queue_item(CMD_CHAR, CH_NINE);
    queue_space();
    queue_item(CMD_CHAR, CH_PLUS);
    queue_item(CMD_CHAR, CH_SLASH);
    queue_end();

    base_count = text_q.size();
    pause_next = 1'b1;
    while (text_q.size() < base_count + 2000) queue_random_text();

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (text_q.size() != 0 || pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
